// File: src/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] HdrByte = 8'hFC;
  localparam logic [ByteW-1:0] TailByte = 8'hFD;

  localparam logic [ByteW-1:0] FirstCmdReset = 8'd65;
  localparam logic [ByteW-1:0] SecondCmdReset = 8'd66;

  localparam logic [CfgIdxW-1:0] RegFirstCmd = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSecondCmd = 2'd1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD    = 4'd1,
    PH_LEN    = 4'd2,
    PH_SEQ    = 4'd3,
    PH_CRC8   = 4'd4,
    PH_CRC16H = 4'd5,
    PH_CRC16L = 4'd6,
    PH_DATA   = 4'd7,
    PH_TAIL   = 4'd8
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_e;

endpackage

// File: src/sensor_frame_deframer_top.sv
// Sensor frame deframer.
// Input channel (rx_valid_i / rx_stall_o / rx_byte_i) carries one received
// serial byte per word. Output channel (res_valid_o / res_stall_i) carries
// at most one result word per input word: a payload byte with its index,
// a frame-complete marker with command and length, or an abort marker.
// Frame: 0xFC, command (must match one of two config codes), length, four
// skipped bytes, payload, tail 0xFD.
// A result is presented in the cycle after its input byte is taken.
// One byte per cycle unless stalled; the parser state update is a single
// combinational step between the state registers and the result register.
// The input is stalled only while a result is held and the receiver stalls,
// so a byte can be taken in the same cycle the held result leaves.
// Config port (cfg_valid_i / cfg_ready_o) is always ready; index 0 and 1
// write the two command codes, other indexes are dropped. Write it only
// while no frame traffic is in flight.
// Reset: parser goes idle, no result pending, command codes return to
// 65 and 66.
module sensor_frame_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rx_valid_i,
  output logic                        rx_stall_o,
  input  logic [sfd_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output logic [sfd_pkg::KindW-1:0]   kind_o,
  output logic [sfd_pkg::ByteW-1:0]   byte_value_o,
  output logic [sfd_pkg::ByteW-1:0]   byte_index_o,
  output logic [sfd_pkg::ByteW-1:0]   frame_cmd_o,
  output logic [sfd_pkg::ByteW-1:0]   frame_length_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfd_pkg::ByteW-1:0]   cfg_data_i
);
  import sfd_pkg::*;

  logic [ByteW-1:0] cmd0_q, cmd1_q;
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] cur_cmd_q, cur_cmd_d;

  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  logic [ByteW-1:0] val_q, val_d;
  logic [ByteW-1:0] idx_q, idx_d;
  logic [ByteW-1:0] ocmd_q;
  logic [ByteW-1:0] olen_q, olen_d;

  logic rx_acc;
  logic has_res;

  assign rx_stall_o = out_valid_q & res_stall_i;
  assign rx_acc = rx_valid_i & ~rx_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd0_q <= FirstCmdReset;
      cmd1_q <= SecondCmdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFirstCmd:  cmd0_q <= cfg_data_i;
        RegSecondCmd: cmd1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser next state and result for the byte at the input.
  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    cur_cmd_d = cur_cmd_q;
    has_res   = 1'b0;
    kind_d    = KIND_ABORT;
    val_d     = '0;
    idx_d     = '0;
    olen_d    = '0;
    case (phase_q)
      PH_IDLE: begin
        if (rx_byte_i == HdrByte) begin
          phase_d   = PH_CMD;
          cur_cmd_d = '0;
        end
      end
      PH_CMD: begin
        if (rx_byte_i == cmd0_q || rx_byte_i == cmd1_q) begin
          phase_d   = PH_LEN;
          len_d     = '0;
          cur_cmd_d = rx_byte_i;
        end else begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end
      end
      PH_LEN: begin
        len_d   = rx_byte_i;
        cnt_d   = ByteW'(1);
        phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        if (len_q == '0) begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end else begin
          phase_d = PH_CRC8;
        end
      end
      PH_CRC8:   phase_d = PH_CRC16H;
      PH_CRC16H: phase_d = PH_CRC16L;
      PH_CRC16L: phase_d = PH_DATA;
      PH_DATA: begin
        if (cnt_q < len_q) begin
          has_res = 1'b1;
          kind_d  = KIND_PAYLOAD;
          val_d   = rx_byte_i;
          idx_d   = cnt_q;
          cnt_d   = cnt_q + ByteW'(1);
        end else begin
          // last counted position is swallowed without output
          phase_d = PH_TAIL;
        end
      end
      PH_TAIL: begin
        phase_d = PH_IDLE;
        has_res = 1'b1;
        if (rx_byte_i == TailByte) begin
          kind_d = KIND_DONE;
          olen_d = len_q;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rx_acc) begin
      out_valid_d = has_res;
    end else if (!res_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      len_q       <= '0;
      cnt_q       <= ByteW'(1);
      cur_cmd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (rx_acc) begin
        phase_q   <= phase_d;
        len_q     <= len_d;
        cnt_q     <= cnt_d;
        cur_cmd_q <= cur_cmd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc && has_res) begin
      kind_q <= kind_d;
      val_q  <= val_d;
      idx_q  <= idx_d;
      ocmd_q <= cur_cmd_d;
      olen_q <= olen_d;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign byte_value_o   = val_q;
  assign byte_index_o   = idx_q;
  assign frame_cmd_o    = ocmd_q;
  assign frame_length_o = olen_q;

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> out_valid_q)
    else $error("input stalled with no result held");

  a_header_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && phase_q == PH_IDLE && rx_byte_i == HdrByte) |=> phase_q == PH_CMD)
    else $error("header byte did not start a frame");

  a_payload_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_PAYLOAD) |-> (idx_q != '0 && idx_q < len_q))
    else $error("payload index outside frame length");

  a_done_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_DONE) |-> (olen_q != '0 && phase_q == PH_IDLE))
    else $error("frame complete with zero length or parser not idle");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(rx_acc))
    else $error("result appeared without an accepted byte");

endmodule
